@@ design/cbba_pkg.sv @@
// ----------------------------------------------------------------------------
// cbba_pkg - shared types and constants for the bitmap block allocator
// Block geometry, command and status codes, the transfer structs and the
// reset contents of the usage map.
// ----------------------------------------------------------------------------
package cbba_pkg;

	// Map geometry
	localparam int NUM_BLOCKS      = 4096;
	localparam int WORD_BITS       = 32;
	localparam int RESERVED_BLOCKS = 6;
	localparam int MAP_WORDS       = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int BLK_AW          = $clog2(NUM_BLOCKS);
	localparam int BIT_AW          = $clog2(WORD_BITS);
	localparam int WORD_AW         = $clog2(MAP_WORDS);
	localparam int CNT_W           = BLK_AW + 1;

	// Allocation scan handles one chunk of a word per cycle
	localparam int CHUNK_BITS = 8;
	localparam int CHUNKS     = WORD_BITS / CHUNK_BITS;
	localparam int CHUNK_AW   = $clog2(CHUNKS);
	localparam int CHUNK_SH   = $clog2(CHUNK_BITS);

	// Command codes
	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_RELEASE = 2'd1;
	localparam logic [1:0] CMD_CHECK   = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [WORD_AW-1:0]   waddr_t;

	typedef struct packed {
		logic [1:0]       command;
		logic [11:0]      first_block;
		logic [12:0]      block_count;
	} cmd_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [11:0]      run_start;
		logic             block_used;
	} res_t;

	// Map access from the sequencer: one read and one write port
	typedef struct packed {
		logic             rd_en;
		waddr_t           rd_addr;
		logic             wr_en;
		waddr_t           wr_addr;
		word_t            wr_data;
	} mem_req_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHK,
		S_SCAN,
		S_UPD,
		S_UPD_END
	} state_t;

	// Reset contents of one map word: the reserved blocks read as used
	function automatic word_t reset_word(input waddr_t w);
		word_t r;
		r = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			if ((int'(w) * WORD_BITS + j) < RESERVED_BLOCKS)
				r[j] = 1'b1;
		end
		return r;
	endfunction

endpackage

@@ design/cbba_map_mem.sv @@
// ----------------------------------------------------------------------------
// cbba_map_mem - usage bitmap storage
// One word per entry, synchronous read with registered data, one write port.
// A per-word valid bit stands in for the reset contents until a word is
// first written back.
// ----------------------------------------------------------------------------
module cbba_map_mem (
	input  logic                clk,
	input  logic                arst_n,
	input  cbba_pkg::mem_req_t  req,
	output cbba_pkg::word_t     rd_word
);
	import cbba_pkg::*;

	word_t            mem [MAP_WORDS];
	logic [MAP_WORDS-1:0] valid_q;
	word_t            rd_data_s1;
	logic             rd_vld_s1;
	waddr_t           rd_addr_s1;

	// Mark words as written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.wr_en) begin
			valid_q[req.wr_addr] <= 1'b1;
		end
	end

	// Write port
	always_ff @(posedge clk) begin
		if (req.wr_en)
			mem[req.wr_addr] <= req.wr_data;
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_s1 <= mem[req.rd_addr];
			rd_vld_s1  <= valid_q[req.rd_addr];
			rd_addr_s1 <= req.rd_addr;
		end
	end

	// Substitute the reset contents for words never written
	assign rd_word = rd_vld_s1 ? rd_data_s1 : reset_word(rd_addr_s1);

endmodule

@@ design/contiguous_bitmap_block_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// contiguous_bitmap_block_allocator_unit - first-fit block allocator
// Keeps a used bit per block in a word memory; allocates the lowest free run,
// releases ranges and checks single blocks.
// ----------------------------------------------------------------------------
//  channel   signals             transfer when
//  command   start, cmd, busy    start high and busy low at a rising edge
//  result    done, result        done high (one cycle, never held off)
//
//  Check: one memory read. Release: reads and writes back each word
//  spanned. Allocate: scans 8 blocks a cycle, then marks the words of
//  the run, or reports no space when no run fits; rejected commands
//  finish without raising busy.
//  Reset is immediate: per-word valid bits supply the reserved blocks.
//  done rises at the edge where busy falls; results cannot stall.
// ----------------------------------------------------------------------------
module contiguous_bitmap_block_allocator_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  cbba_pkg::cmd_t  cmd,
	output logic            busy,
	output logic            done,
	output cbba_pkg::res_t  result
);
	import cbba_pkg::*;

	localparam logic [CHUNK_AW-1:0] CHUNK_LAST = CHUNK_AW'(CHUNKS - 1);
	localparam waddr_t              WORD_LAST  = WORD_AW'(MAP_WORDS - 1);

	state_t                 state_q, state_d;
	mem_req_t               req;
	word_t                  rd_word;
	logic                   accept;
	logic                   fin;
	res_t                   fin_res;
	logic                   done_q;
	res_t                   result_q;

	// Scan registers
	logic [CHUNK_AW-1:0]    chunk_q;
	waddr_t                 scan_w_q;
	logic [CNT_W-1:0]       run_q;
	logic [BLK_AW-1:0]      start_q;
	logic [CNT_W-1:0]       count_q;
	word_t                  word_q;

	// Range update registers
	logic [BLK_AW-1:0]      lo_q, hi_q;
	logic                   set_q;
	waddr_t                 upd_w_q;
	logic                   upd_s1;
	waddr_t                 wr_addr_s1;
	logic [BIT_AW-1:0]      bit_q;

	logic [CNT_W:0]         rel_end;
	word_t                  scan_src;
	logic [CHUNK_BITS-1:0]  chunk_bits;
	logic [CNT_W-1:0]       scan_run;
	logic [BLK_AW-1:0]      scan_st;
	logic                   scan_fnd;
	logic [BLK_AW-1:0]      scan_hi;
	word_t                  lo_mask, hi_mask, upd_mask, upd_word;

	cbba_map_mem u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_word (rd_word)
	);

	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign rel_end = (CNT_W+1)'(cmd.first_block) + (CNT_W+1)'(cmd.block_count);

	// Scan one chunk: carry the free run through eight blocks
	assign scan_src   = (chunk_q == '0) ? rd_word : word_q;
	assign chunk_bits = CHUNK_BITS'(scan_src >> {chunk_q, CHUNK_SH'(0)});

	always_comb begin
		logic [BLK_AW-1:0] b;
		scan_run = run_q;
		scan_st  = start_q;
		scan_fnd = 1'b0;
		for (int k = 0; k < CHUNK_BITS; k++) begin
			b = {scan_w_q, chunk_q, CHUNK_SH'(k)};
			if (!scan_fnd) begin
				if (chunk_bits[k]) begin
					scan_run = '0;
				end else begin
					if (scan_run == '0)
						scan_st = b;
					scan_run = scan_run + CNT_W'(1);
					if (scan_run == count_q)
						scan_fnd = 1'b1;
				end
			end
		end
	end

	assign scan_hi = BLK_AW'(CNT_W'(scan_st) + count_q - CNT_W'(1));

	// Build the bit mask for the word being written back
	always_comb begin
		lo_mask = '1;
		hi_mask = '1;
		if (wr_addr_s1 == lo_q[BLK_AW-1:BIT_AW])
			lo_mask = word_t'('1) << lo_q[BIT_AW-1:0];
		if (wr_addr_s1 == hi_q[BLK_AW-1:BIT_AW])
			hi_mask = word_t'('1) >> (BIT_AW'(WORD_BITS - 1) - hi_q[BIT_AW-1:0]);
		upd_mask = lo_mask & hi_mask;
		upd_word = set_q ? (rd_word | upd_mask) : (rd_word & ~upd_mask);
	end

	// Next state, memory requests and result
	always_comb begin
		state_d = state_q;
		req     = '0;
		fin     = 1'b0;
		fin_res = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd.command)
						CMD_ALLOC: begin
							if (cmd.block_count == '0 ||
							    cmd.block_count > CNT_W'(NUM_BLOCKS)) begin
								fin            = 1'b1;
								fin_res.status = ST_NOSPACE;
							end else begin
								req.rd_en   = 1'b1;
								req.rd_addr = '0;
								state_d     = S_SCAN;
							end
						end
						CMD_RELEASE: begin
							if (rel_end > (CNT_W+1)'(NUM_BLOCKS)) begin
								fin            = 1'b1;
								fin_res.status = ST_RANGE;
							end else if (cmd.block_count == '0) begin
								fin            = 1'b1;
								fin_res.status = ST_OK;
							end else begin
								state_d = S_UPD;
							end
						end
						CMD_CHECK: begin
							// a 12-bit block number always lies inside the map
							req.rd_en   = 1'b1;
							req.rd_addr = cmd.first_block[BLK_AW-1:BIT_AW];
							state_d     = S_CHK;
						end
						default: begin
							fin            = 1'b1;
							fin_res.status = ST_RANGE;
						end
					endcase
				end
			end
			S_CHK: begin
				fin                = 1'b1;
				fin_res.status     = ST_OK;
				fin_res.block_used = rd_word[bit_q];
				state_d            = S_IDLE;
			end
			S_SCAN: begin
				if (scan_fnd) begin
					state_d = S_UPD;
				end else if (chunk_q == CHUNK_LAST) begin
					if (scan_w_q == WORD_LAST) begin
						fin            = 1'b1;
						fin_res.status = ST_NOSPACE;
						state_d        = S_IDLE;
					end else begin
						// fetch the next word for chunk zero
						req.rd_en   = 1'b1;
						req.rd_addr = scan_w_q + waddr_t'(1);
					end
				end
			end
			S_UPD: begin
				req.rd_en   = 1'b1;
				req.rd_addr = upd_w_q;
				if (upd_w_q == hi_q[BLK_AW-1:BIT_AW])
					state_d = S_UPD_END;
			end
			S_UPD_END: begin
				fin               = 1'b1;
				fin_res.status    = ST_OK;
				fin_res.run_start = start_q;
				state_d           = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		// write back the word read in the previous update cycle
		req.wr_en   = upd_s1;
		req.wr_addr = wr_addr_s1;
		req.wr_data = upd_word;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			upd_s1  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			upd_s1  <= (state_q == S_UPD);
			done_q  <= fin;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (fin)
			result_q <= fin_res;
		wr_addr_s1 <= upd_w_q;
		case (state_q)
			S_IDLE: begin
				// load the command
				count_q  <= cmd.block_count;
				bit_q    <= cmd.first_block[BIT_AW-1:0];
				run_q    <= '0;
				start_q  <= '0;
				scan_w_q <= '0;
				chunk_q  <= '0;
				lo_q     <= cmd.first_block;
				hi_q     <= BLK_AW'(rel_end - (CNT_W+1)'(1));
				upd_w_q  <= cmd.first_block[BLK_AW-1:BIT_AW];
				set_q    <= 1'b0;
			end
			S_SCAN: begin
				// advance the scan, hold the word for the later chunks
				run_q   <= scan_run;
				start_q <= scan_st;
				chunk_q <= chunk_q + CHUNK_AW'(1);
				if (chunk_q == '0)
					word_q <= rd_word;
				if (chunk_q == CHUNK_LAST)
					scan_w_q <= scan_w_q + waddr_t'(1);
				if (scan_fnd) begin
					lo_q    <= scan_st;
					hi_q    <= scan_hi;
					upd_w_q <= scan_st[BLK_AW-1:BIT_AW];
					set_q   <= 1'b1;
				end
			end
			S_UPD: begin
				upd_w_q <= upd_w_q + waddr_t'(1);
			end
			default: begin
			end
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	// a result only follows a cycle of work or an accepted command
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) != S_IDLE) || $past(accept))
		else $error("result without a command");

	// the map is only written during a range update
	a_write_in_update: assert property (@(posedge clk) disable iff (!arst_n)
		req.wr_en |-> (state_q == S_UPD) || (state_q == S_UPD_END))
		else $error("map write outside a range update");

	// the scan moves one chunk per cycle
	a_scan_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) && ($past(state_q) == S_SCAN) |->
		chunk_q == CHUNK_AW'($past(chunk_q) + CHUNK_AW'(1)))
		else $error("scan chunk skipped");

	// a failed command carries no run start and no used flag
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status != ST_OK) |->
		(result.run_start == '0) && !result.block_used)
		else $error("failed result carries data");
`endif

endmodule
